// ===== rtl/cfc_pkg.sv =====
// Shared types and constants for the checksum frame checker.
package cfc_pkg;

    localparam int PAYLOAD_BYTES = 12;
    localparam int POS_W         = 4;
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES);
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [POS_W-1:0] POS_HUNT   = 4'd0;
    localparam logic [POS_W-1:0] POS_FIRST  = 4'd1;
    localparam logic [POS_W-1:0] POS_LAST   = 4'(PAYLOAD_BYTES);
    localparam logic [POS_W-1:0] POS_CHECK  = 4'(PAYLOAD_BYTES + 1);
    localparam logic [POS_W-1:0] POS_FOOTER = 4'(PAYLOAD_BYTES + 2);

    localparam logic [7:0] HEADER_RESET = 8'hAA;
    localparam logic [7:0] FOOTER_RESET = 8'h55;

    localparam logic CFG_HEADER = 1'b0;
    localparam logic CFG_FOOTER = 1'b1;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_SUM    = 2'd1;
    localparam logic [1:0] STATUS_BAD_FOOTER = 2'd2;

    typedef enum logic [1:0] {
        KIND_HEADER,
        KIND_PAYLOAD,
        KIND_CHECK,
        KIND_FOOTER
    } cfc_kind_t;

    typedef struct packed {
        cfc_kind_t        kind;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
        logic             footer_ok;
    } cfc_item_t;

endpackage

// ===== rtl/cfc_front.sv =====
// Front end: configuration registers, frame position tracking and word classification.
module cfc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              q_full,
    output logic              q_push,
    output cfc_pkg::cfc_item_t q_item
);

    logic [7:0]               header_reg;
    logic [7:0]               footer_reg;
    logic [cfc_pkg::POS_W-1:0] pos_reg;
    logic [cfc_pkg::POS_W-1:0] pos_next;
    logic                     s_fire;
    logic [cfc_pkg::POS_W-1:0] pos_idx;

    assign s_tready = !q_full;
    assign s_fire   = s_tvalid && s_tready;
    assign pos_idx  = pos_reg - cfc_pkg::POS_FIRST;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= cfc_pkg::HEADER_RESET;
            footer_reg <= cfc_pkg::FOOTER_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                cfc_pkg::CFG_HEADER: header_reg <= cfg_data;
                cfc_pkg::CFG_FOOTER: footer_reg <= cfg_data;
                default:             header_reg <= header_reg;
            endcase
        end
    end

    always_comb begin
        pos_next         = pos_reg;
        q_push           = 1'b0;
        q_item.kind      = cfc_pkg::KIND_HEADER;
        q_item.idx       = pos_idx[cfc_pkg::IDX_W-1:0];
        q_item.data      = s_tdata;
        q_item.footer_ok = (s_tdata == footer_reg);
        if (s_fire) begin
            priority if (pos_reg >= cfc_pkg::POS_FIRST && pos_reg <= cfc_pkg::POS_LAST) begin
                q_item.kind = cfc_pkg::KIND_PAYLOAD;
                q_push      = 1'b1;
                pos_next    = pos_reg + 1'b1;
            end else if (pos_reg == cfc_pkg::POS_CHECK) begin
                q_item.kind = cfc_pkg::KIND_CHECK;
                q_push      = 1'b1;
                pos_next    = cfc_pkg::POS_FOOTER;
            end else if (pos_reg == cfc_pkg::POS_FOOTER) begin
                q_item.kind = cfc_pkg::KIND_FOOTER;
                q_push      = 1'b1;
                pos_next    = cfc_pkg::POS_HUNT;
            end else if (s_tdata == header_reg) begin
                q_item.kind = cfc_pkg::KIND_HEADER;
                q_push      = 1'b1;
                pos_next    = cfc_pkg::POS_FIRST;
            end else begin
                pos_next    = cfc_pkg::POS_HUNT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= cfc_pkg::POS_HUNT;
        end else begin
            pos_reg <= pos_next;
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= cfc_pkg::POS_FOOTER)
        else $error("frame position out of range");
`endif

endmodule

// ===== rtl/cfc_queue.sv =====
// Short FIFO of classified words between front end and back end.
module cfc_queue #(
    parameter int DEPTH = cfc_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  cfc_pkg::cfc_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output cfc_pkg::cfc_item_t head_item
);

    localparam int PTR_W = $clog2(DEPTH);

    cfc_pkg::cfc_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;

    assign full       = (count_reg == (PTR_W+1)'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/cfc_back.sv =====
// Back end: payload store, checksum accumulation and result register.
module cfc_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               head_valid,
    input  cfc_pkg::cfc_item_t head_item,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [103:0]       m_tdata
);

    logic [7:0]  store_reg [cfc_pkg::PAYLOAD_BYTES];
    logic [7:0]  sum_reg;
    logic [7:0]  check_reg;
    logic        m_valid_reg;
    logic [97:0] m_data_reg;
    logic [1:0]  status;
    logic        is_footer;

    assign is_footer = (head_item.kind == cfc_pkg::KIND_FOOTER);
    assign pop       = head_valid && (!is_footer || !m_valid_reg || m_tready);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {6'd0, m_data_reg};

    always_comb begin
        priority if (!head_item.footer_ok) begin
            status = cfc_pkg::STATUS_BAD_FOOTER;
        end else if (sum_reg != check_reg) begin
            status = cfc_pkg::STATUS_BAD_SUM;
        end else begin
            status = cfc_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && head_item.kind == cfc_pkg::KIND_PAYLOAD) begin
            store_reg[head_item.idx] <= head_item.data;
        end
        if (pop && is_footer) begin
            m_data_reg <= {status,
                           store_reg[11], store_reg[10], store_reg[9], store_reg[8],
                           store_reg[7], store_reg[6], store_reg[5], store_reg[4],
                           store_reg[3], store_reg[2], store_reg[1], store_reg[0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            check_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                unique case (head_item.kind)
                    cfc_pkg::KIND_HEADER: begin
                        sum_reg   <= '0;
                        check_reg <= '0;
                    end
                    cfc_pkg::KIND_PAYLOAD: sum_reg   <= sum_reg + head_item.data;
                    cfc_pkg::KIND_CHECK:   check_reg <= head_item.data;
                    default:               sum_reg   <= sum_reg;
                endcase
            end
            if (pop && is_footer) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_result_from_footer: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(pop && is_footer))
        else $error("result raised without a footer word");
`endif

endmodule

// ===== rtl/checksum_frame_checker.sv =====
// Top level: checksum frame checker with decoupled front end and back end.
// Throughput: one byte word per cycle, sustained, while the result side keeps up.
// Result path: an accepted footer word passes through the QUEUE_DEPTH-entry queue and then the
//   result register, and it waits in the queue while a stalled result is still held.
// Reset (aresetn low, synchronous): hunt for header, empty queue, clear sums and
//   result valid, header register to 0xAA and footer register to 0x55.
module checksum_frame_checker #(
    parameter int QUEUE_DEPTH = cfc_pkg::QUEUE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [7:0]   cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // [7:0] rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata     // [31:0] first_word, [63:32] middle_word,
                                     // [95:64] third_word, [97:96] frame_status
);

    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_head_valid;
    cfc_pkg::cfc_item_t q_push_item;
    cfc_pkg::cfc_item_t q_head_item;

    cfc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_push_item)
    );

    cfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (q_push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_item  (q_head_item)
    );

    cfc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_item  (q_head_item),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== bench/frame_result_checker.sv =====
// Frame result checker: predicts each decoded frame from the byte stream and compares results.
module frame_result_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [7:0]   cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,    // [7:0] rx_byte
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,    // [31:0] first_word, [63:32] middle_word,
                                     // [95:64] third_word, [97:96] frame_status
    output int           mismatches,
    output int           pending
);

    typedef struct {
        logic [31:0] first_word;
        logic [31:0] middle_word;
        logic [31:0] third_word;
        logic [1:0]  frame_status;
    } frame_result_t;

    frame_result_t             frames_due[$];
    logic [cfc_pkg::POS_W-1:0] pos;
    logic [7:0]                sum_acc;
    logic [7:0]                check_byte;
    logic [7:0]                hdr_val;
    logic [7:0]                ftr_val;
    logic [7:0]                payload [cfc_pkg::PAYLOAD_BYTES];

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    function automatic logic [31:0] payload_word(input int base);
        return {payload[base+3], payload[base+2], payload[base+1], payload[base]};
    endfunction

    task automatic report(input string msg);
        $display("%0t frame checker: %s", $time, msg);
        mismatches++;
    endtask

    task automatic absorb_rx_byte(input logic [7:0] b);
        frame_result_t r;
        if (pos >= cfc_pkg::POS_FIRST && pos <= cfc_pkg::POS_LAST) begin
            payload[pos - cfc_pkg::POS_FIRST] = b;
            sum_acc = sum_acc + b;
            pos = pos + 1'b1;
        end else if (pos == cfc_pkg::POS_CHECK) begin
            check_byte = b;
            pos = cfc_pkg::POS_FOOTER;
        end else if (pos == cfc_pkg::POS_FOOTER) begin
            r.first_word  = payload_word(0);
            r.middle_word = payload_word(4);
            r.third_word  = payload_word(8);
            if (b != ftr_val)
                r.frame_status = cfc_pkg::STATUS_BAD_FOOTER;
            else if (sum_acc != check_byte)
                r.frame_status = cfc_pkg::STATUS_BAD_SUM;
            else
                r.frame_status = cfc_pkg::STATUS_OK;
            frames_due.push_back(r);
            pos = cfc_pkg::POS_HUNT;
        end else if (b == hdr_val) begin
            sum_acc    = 8'd0;
            check_byte = 8'd0;
            pos        = cfc_pkg::POS_FIRST;
        end else begin
            pos = cfc_pkg::POS_HUNT;
        end
    endtask

    task automatic compare_result(input logic [103:0] d);
        frame_result_t w;
        if (frames_due.size() == 0) begin
            report($sformatf("result word with no frame due, data %h", d));
            return;
        end
        w = frames_due.pop_front();
        if (d[31:0] !== w.first_word)
            report($sformatf("first_word got %h want %h", d[31:0], w.first_word));
        if (d[63:32] !== w.middle_word)
            report($sformatf("middle_word got %0d want %0d",
                             $signed(d[63:32]), $signed(w.middle_word)));
        if (d[95:64] !== w.third_word)
            report($sformatf("third_word got %h want %h", d[95:64], w.third_word));
        if (d[97:96] !== w.frame_status)
            report($sformatf("frame_status got %0d want %0d", d[97:96], w.frame_status));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pos        = cfc_pkg::POS_HUNT;
            sum_acc    = 8'd0;
            check_byte = 8'd0;
            hdr_val    = cfc_pkg::HEADER_RESET;
            ftr_val    = cfc_pkg::FOOTER_RESET;
            frames_due.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == cfc_pkg::CFG_HEADER)
                    hdr_val = cfg_data;
                else
                    ftr_val = cfg_data;
            end
            if (m_tvalid && m_tready)
                compare_result(m_tdata);
            if (s_tvalid && s_tready)
                absorb_rx_byte(s_tdata);
        end
        pending <= frames_due.size();
    end

endmodule

// ===== bench/tb_checksum_frame_checker.sv =====
// Testbench top: byte stream stimulus, result backpressure, watchdog and verdict.
module tb_checksum_frame_checker;

    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_WORDS  = 275;
    localparam int NUM_PHASES   = 6;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         cfg_wr_en;
    logic         cfg_index;
    logic [7:0]   cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;

    int           mismatches;
    int           pending;
    int           quiet_cycles = 0;
    int           words_sent = 0;
    bit           calm = 1'b0;
    bit           stall_req = 1'b0;
    logic [7:0]   hdr_cfg = cfc_pkg::HEADER_RESET;
    logic [7:0]   ftr_cfg = cfc_pkg::FOOTER_RESET;
    logic [7:0]   hdr_plan [NUM_PHASES];
    logic [7:0]   ftr_plan [NUM_PHASES];

    always #2 aclk = ~aclk;

    checksum_frame_checker i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    frame_result_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // hold off the result side on request, otherwise stall at random
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_req) begin
                stall_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 6);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                    $display("tb_checksum_frame_checker NOT OK");
                    $finish;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(15))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return hdr_cfg;
            3:       return ftr_cfg;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_frame();
        logic [7:0] b;
        logic [7:0] sum;
        int         pick;
        int         cut;
        sum  = 8'd0;
        pick = $urandom_range(9);
        cut  = ($urandom_range(19) == 0) ? $urandom_range(cfc_pkg::PAYLOAD_BYTES - 1)
                                         : cfc_pkg::PAYLOAD_BYTES;
        send_byte(hdr_cfg);
        for (int i = 0; i < cfc_pkg::PAYLOAD_BYTES; i++) begin
            if (i == cut)
                return;
            b = pick_byte();
            sum = sum + b;
            send_byte(b);
        end
        if (pick == 7 || pick == 9)
            sum = sum + 8'($urandom_range(1, 255));
        send_byte(sum);
        if (pick >= 8)
            send_byte(ftr_cfg ^ 8'($urandom_range(1, 255)));
        else
            send_byte(ftr_cfg);
    endtask

    task automatic send_known_frame();
        logic [7:0] body [cfc_pkg::PAYLOAD_BYTES];
        logic [7:0] sum;
        body = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h80,
                 cfc_pkg::HEADER_RESET, 8'h00, 8'hFF, 8'h7F};
        sum  = 8'd0;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(hdr_cfg);
        foreach (body[i]) begin
            sum = sum + body[i];
            send_byte(body[i]);
        end
        send_byte(sum);
        send_byte(ftr_cfg);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (cfc_pkg::QUEUE_DEPTH + 8) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [7:0] h, input logic [7:0] f);
        cfg_wr_en <= 1'b1;
        cfg_index <= cfc_pkg::CFG_HEADER;
        cfg_data  <= h;
        @(posedge aclk);
        cfg_index <= cfc_pkg::CFG_FOOTER;
        cfg_data  <= f;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        hdr_cfg = h;
        ftr_cfg = f;
    endtask

    initial begin
        int start;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= cfc_pkg::CFG_HEADER;
        cfg_data  <= 8'h00;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        hdr_plan = '{cfc_pkg::HEADER_RESET, 8'h00, 8'hFF, 8'h5A, 8'h00,
                     cfc_pkg::HEADER_RESET};
        ftr_plan = '{cfc_pkg::FOOTER_RESET, 8'hFF, 8'h00, 8'h5A, 8'h00,
                     cfc_pkg::FOOTER_RESET};
        hdr_plan[4] = 8'($urandom_range(255));
        ftr_plan[4] = 8'($urandom_range(255));
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                drain();
                write_regs(hdr_plan[p], ftr_plan[p]);
            end
            calm = (p == 1);
            if (p == 2)
                stall_req = 1'b1;
            if (p == 0)
                send_known_frame();
            start = words_sent;
            while (words_sent - start < PHASE_WORDS) begin
                if ($urandom_range(4) == 0)
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
                send_frame();
            end
        end

        drain();
        if (mismatches == 0)
            $display("tb_checksum_frame_checker OK");
        else
            $display("tb_checksum_frame_checker NOT OK");
        $finish;
    end

endmodule
